[rtl/safety_status_led_classifier_macros.svh]
// Assertion macros for the safety status LED classifier checker.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef SAFETY_STATUS_LED_CLASSIFIER_MACROS_SVH
`define SAFETY_STATUS_LED_CLASSIFIER_MACROS_SVH

// Same-cycle implication, off during reset.
`define SSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("safety status LED classifier check failed");

// Next-cycle implication, off during reset.
`define SSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("safety status LED classifier check failed");

// Condition in the cycle after reset is seen.
`define SSL_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("safety status LED classifier check failed");

`endif

[rtl/ssl_pkg.sv]
// Shared types and constants for the safety status LED classifier.
// No dependencies; every other file but the macros header imports this package.
package ssl_pkg;

  typedef enum logic [1:0] {
    DISP_SAFE     = 2'd0,
    DISP_WARN     = 2'd1,
    DISP_DANGER   = 2'd2,
    DISP_OVERRIDE = 2'd3
  } disp_state_t;

  typedef enum logic [2:0] {
    CFG_TEMP_DANGER_BELOW = 3'd0,
    CFG_TEMP_WARN_BELOW   = 3'd1,
    CFG_TEMP_WARN_ABOVE   = 3'd2,
    CFG_TEMP_DANGER_ABOVE = 3'd3,
    CFG_BATT_DANGER_BELOW = 3'd4,
    CFG_BATT_WARN_BELOW   = 3'd5,
    CFG_FLASH_PERIOD      = 3'd6
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [9:0] HUM_DANGER_BELOW = 10'd200;
  localparam logic [9:0] HUM_WARN_BELOW   = 10'd300;
  localparam logic [9:0] HUM_WARN_ABOVE   = 10'd800;
  localparam logic [9:0] HUM_DANGER_ABOVE = 10'd900;

  localparam logic [7:0] LEVEL_FULL        = 8'd30;
  localparam logic [7:0] LEVEL_AMBER_GREEN = 8'd12;
  localparam logic [7:0] LEVEL_OFF         = 8'd0;

  localparam logic [7:0] SINCE_MAX  = 8'd255;
  localparam logic [2:0] SHOWN_NONE = 3'd7;

  typedef struct packed {
    logic signed [11:0] temperature_tenths;
    logic               temperature_valid;
    logic [9:0]         humidity_tenths;
    logic               humidity_valid;
    logic [12:0]        battery_mv;
    logic               battery_valid;
    logic               hard_impact;
    logic               lying_too_long;
    logic               remote_override;
  } ssl_in_t;

  typedef struct packed {
    disp_state_t display_state;
    logic        flash_lit;
    logic        led_update;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
  } ssl_out_t;

  typedef struct packed {
    logic signed [11:0] temp_danger_below;
    logic signed [11:0] temp_warn_below;
    logic signed [11:0] temp_warn_above;
    logic signed [11:0] temp_danger_above;
    logic [12:0]        batt_danger_below_mv;
    logic [12:0]        batt_warn_below_mv;
    logic [7:0]         flash_period_items;
  } ssl_cfg_t;

endpackage

[rtl/ssl_cfg_regs.sv]
// Threshold and flash period registers behind the plain write port.
// Depends on ssl_pkg.
module ssl_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ssl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ssl_pkg::ssl_cfg_t               cfg
);
  import ssl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_danger_below    <= 12'sd0;
      cfg.temp_warn_below      <= 12'sd100;
      cfg.temp_warn_above      <= 12'sd350;
      cfg.temp_danger_above    <= 12'sd450;
      cfg.batt_danger_below_mv <= 13'd3400;
      cfg.batt_warn_below_mv   <= 13'd3700;
      cfg.flash_period_items   <= 8'd5;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TEMP_DANGER_BELOW: cfg.temp_danger_below    <= $signed(cfg_data[11:0]);
        CFG_TEMP_WARN_BELOW:   cfg.temp_warn_below      <= $signed(cfg_data[11:0]);
        CFG_TEMP_WARN_ABOVE:   cfg.temp_warn_above      <= $signed(cfg_data[11:0]);
        CFG_TEMP_DANGER_ABOVE: cfg.temp_danger_above    <= $signed(cfg_data[11:0]);
        CFG_BATT_DANGER_BELOW: cfg.batt_danger_below_mv <= cfg_data[12:0];
        CFG_BATT_WARN_BELOW:   cfg.batt_warn_below_mv   <= cfg_data[12:0];
        CFG_FLASH_PERIOD:      cfg.flash_period_items   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/ssl_grade.sv]
// Window comparators that grade one sensor snapshot safe, warning or danger.
// Depends on ssl_pkg; purely combinational.
module ssl_grade (
  input  ssl_pkg::ssl_in_t    snap,
  input  ssl_pkg::ssl_cfg_t   cfg,
  output ssl_pkg::disp_state_t grade
);
  import ssl_pkg::*;

  logic temp_danger, temp_warn;
  logic hum_danger, hum_warn;
  logic batt_danger, batt_warn;
  logic danger, warn;

  always_comb begin
    temp_danger = ($signed(snap.temperature_tenths) < $signed(cfg.temp_danger_below)) ||
                  ($signed(snap.temperature_tenths) > $signed(cfg.temp_danger_above));
    temp_warn   = ($signed(snap.temperature_tenths) < $signed(cfg.temp_warn_below)) ||
                  ($signed(snap.temperature_tenths) > $signed(cfg.temp_warn_above));
    hum_danger  = (snap.humidity_tenths < HUM_DANGER_BELOW) ||
                  (snap.humidity_tenths > HUM_DANGER_ABOVE);
    hum_warn    = (snap.humidity_tenths < HUM_WARN_BELOW) ||
                  (snap.humidity_tenths > HUM_WARN_ABOVE);
    batt_danger = snap.battery_mv < cfg.batt_danger_below_mv;
    batt_warn   = snap.battery_mv < cfg.batt_warn_below_mv;

    danger = snap.hard_impact || snap.lying_too_long ||
             (snap.temperature_valid && temp_danger) ||
             (snap.humidity_valid && hum_danger) ||
             (snap.battery_valid && batt_danger);
    warn   = (snap.temperature_valid && temp_warn) ||
             (snap.humidity_valid && hum_warn) ||
             (snap.battery_valid && batt_warn);

    if (danger) begin
      grade = DISP_DANGER;
    end else if (warn) begin
      grade = DISP_WARN;
    end else begin
      grade = DISP_SAFE;
    end
  end

endmodule

[rtl/ssl_display.sv]
// Flash timing, change detection and RGB levels for one status transaction.
// Depends on ssl_pkg; holds the loop state, updated when advance is high.
module ssl_display (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 remote_override,
  input  ssl_pkg::disp_state_t grade,
  input  logic [7:0]           flash_period_items,
  output ssl_pkg::ssl_out_t    result
);
  import ssl_pkg::*;

  logic [7:0] since_toggle, since_toggle_next;
  logic       flash_phase, flash_phase_next;
  logic [2:0] last_shown_state, last_shown_state_next;
  logic       last_shown_phase, last_shown_phase_next;

  disp_state_t show;
  logic        lit;
  logic        upd;

  always_comb begin
    if (remote_override) begin
      show = DISP_OVERRIDE;
      if (since_toggle >= flash_period_items) begin
        flash_phase_next  = ~flash_phase;
        since_toggle_next = 8'd1;
      end else begin
        flash_phase_next  = flash_phase;
        since_toggle_next = (since_toggle == SINCE_MAX) ? since_toggle : since_toggle + 8'd1;
      end
      lit = flash_phase_next;
    end else begin
      show              = grade;
      flash_phase_next  = 1'b1;
      since_toggle_next = 8'd1;
      lit               = 1'b1;
    end

    upd = ({1'b0, show} != last_shown_state) || (lit != last_shown_phase);
    last_shown_state_next = upd ? {1'b0, show} : last_shown_state;
    last_shown_phase_next = upd ? lit : last_shown_phase;

    result.display_state = show;
    result.flash_lit     = lit;
    result.led_update    = upd;
    result.blue_level    = LEVEL_OFF;
    case (show)
      DISP_SAFE: begin
        result.red_level   = LEVEL_OFF;
        result.green_level = LEVEL_FULL;
      end
      DISP_WARN: begin
        result.red_level   = LEVEL_FULL;
        result.green_level = LEVEL_AMBER_GREEN;
      end
      DISP_DANGER: begin
        result.red_level   = LEVEL_FULL;
        result.green_level = LEVEL_OFF;
      end
      default: begin
        result.red_level   = lit ? LEVEL_FULL : LEVEL_OFF;
        result.green_level = LEVEL_OFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_toggle     <= 8'd0;
      flash_phase      <= 1'b1;
      last_shown_state <= SHOWN_NONE;
      last_shown_phase <= 1'b0;
    end else if (advance) begin
      since_toggle     <= since_toggle_next;
      flash_phase      <= flash_phase_next;
      last_shown_state <= last_shown_state_next;
      last_shown_phase <= last_shown_phase_next;
    end
  end

endmodule

[rtl/safety_status_led_classifier.sv]
// Safety status LED classifier top level: input register, grading,
// display logic and result register. Depends on ssl_pkg, ssl_cfg_regs, ssl_grade and ssl_display.
//
// Usage:
//   snap_valid/snap_ready carry one sensor snapshot per transaction (ssl_in_t).
//   status_valid/status_ready carry one display result per snapshot (ssl_out_t).
//   cfg_write/cfg_index/cfg_data write a threshold or the flash period;
//   write only while no transaction is in flight.
// Timing:
//   A snapshot taken into the input register is graded from there and written
//   to the result register when that is free or being taken on status.
//   One transaction per cycle is sustained while status_ready stays high; the
//   figure is set by the single comparator and counter pass between the two registers.
// Reset:
//   rst clears the valid bits of both register stages and restores the default thresholds,
//   a lit flash phase and a "nothing shown yet" display record.
// Stall:
//   While status_ready is low the result holds; the input register still takes
//   one more snapshot, then snap_ready drops until the result is taken.
module safety_status_led_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            snap_valid,
  output logic                            snap_ready,
  input  ssl_pkg::ssl_in_t                snap,
  output logic                            status_valid,
  input  logic                            status_ready,
  output ssl_pkg::ssl_out_t               status,
  input  logic                            cfg_write,
  input  logic [ssl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ssl_pkg::*;

  ssl_cfg_t    cfg;
  ssl_in_t     stage;
  logic        stage_valid;
  logic        advance;
  disp_state_t grade;
  ssl_out_t    result;

  assign advance    = stage_valid && (!status_valid || status_ready);
  assign snap_ready = !stage_valid || advance;

  ssl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssl_grade u_grade (
    .snap  (stage),
    .cfg   (cfg),
    .grade (grade)
  );

  ssl_display u_display (
    .clk                (clk),
    .rst                (rst),
    .advance            (advance),
    .remote_override    (stage.remote_override),
    .grade              (grade),
    .flash_period_items (cfg.flash_period_items),
    .result             (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      stage <= snap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (advance) begin
      status_valid <= 1'b1;
    end else if (status_ready) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status <= result;
    end
  end

endmodule

[rtl/ssl_checker.sv]
// Port-level checks for the safety status LED classifier, bound to the top.
// Depends on ssl_pkg and safety_status_led_classifier_macros.svh.
`include "safety_status_led_classifier_macros.svh"

module ssl_checker (
  input logic              clk,
  input logic              rst,
  input logic              status_valid,
  input logic              status_ready,
  input ssl_pkg::ssl_out_t status
);
  import ssl_pkg::*;

  logic stalled;
  logic steady_due;
  logic safe_due;
  logic safe_levels;
  logic unlit_due;
  logic dark_levels;

  assign stalled     = status_valid && !status_ready;
  assign steady_due  = status_valid && (status.display_state != DISP_OVERRIDE);
  assign safe_due    = status_valid && (status.display_state == DISP_SAFE);
  assign safe_levels = (status.red_level == LEVEL_OFF) && (status.green_level == LEVEL_FULL);
  assign unlit_due   = status_valid && !status.flash_lit;
  assign dark_levels = (status.red_level == LEVEL_OFF) && (status.green_level == LEVEL_OFF) &&
                       (status.blue_level == LEVEL_OFF);

  `SSL_ASSERT_AFTER_RESET(a_idle_after_reset, !status_valid)
  `SSL_ASSERT_NEXT(a_stall_holds, stalled, status_valid && $stable(status))
  `SSL_ASSERT_NOW(a_lit_outside_override, steady_due, status.flash_lit)
  `SSL_ASSERT_NOW(a_safe_is_green, safe_due, safe_levels)
  `SSL_ASSERT_NOW(a_unlit_is_dark, unlit_due, dark_levels)

endmodule

bind safety_status_led_classifier ssl_checker u_ssl_checker (.*);

[tb/safety_status_led_classifier_checker.sv]
// Checker for the safety status LED classifier: watches the snapshot, status
// and register write ports, predicts each status and compares field by field.
// Depends on ssl_pkg only.
module safety_status_led_classifier_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            snap_valid,
  input  logic                            snap_ready,
  input  ssl_pkg::ssl_in_t                snap,
  input  logic                            status_valid,
  input  logic                            status_ready,
  input  ssl_pkg::ssl_out_t               status,
  input  logic                            cfg_write,
  input  logic [ssl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              outstanding,
  output int                              checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssl_pkg::*;

  ssl_cfg_t   thr;
  logic [7:0] since_cnt;
  logic       phase_lit;
  logic [2:0] shown_state;
  logic       shown_phase;
  ssl_out_t   status_due_q[$];
  ssl_out_t   want;
  int         err_cnt = 0;
  int         checked_cnt = 0;

  function automatic ssl_out_t predict_status(input ssl_in_t s);
    ssl_out_t    o;
    logic        danger;
    logic        warn;
    logic        lit;
    disp_state_t show;
    o = '0;
    if (s.remote_override) begin
      show = DISP_OVERRIDE;
      if (since_cnt >= thr.flash_period_items) begin
        phase_lit = ~phase_lit;
        since_cnt = 8'd1;
      end else if (since_cnt < SINCE_MAX) begin
        since_cnt = since_cnt + 8'd1;
      end
      lit = phase_lit;
    end else begin
      danger = s.hard_impact | s.lying_too_long;
      warn = 1'b0;
      if (s.temperature_valid) begin
        if ($signed(s.temperature_tenths) < $signed(thr.temp_danger_below) ||
            $signed(s.temperature_tenths) > $signed(thr.temp_danger_above)) begin
          danger = 1'b1;
        end else if ($signed(s.temperature_tenths) < $signed(thr.temp_warn_below) ||
                     $signed(s.temperature_tenths) > $signed(thr.temp_warn_above)) begin
          warn = 1'b1;
        end
      end
      if (s.humidity_valid) begin
        if (s.humidity_tenths < HUM_DANGER_BELOW || s.humidity_tenths > HUM_DANGER_ABOVE) begin
          danger = 1'b1;
        end else if (s.humidity_tenths < HUM_WARN_BELOW ||
                     s.humidity_tenths > HUM_WARN_ABOVE) begin
          warn = 1'b1;
        end
      end
      if (s.battery_valid) begin
        if (s.battery_mv < thr.batt_danger_below_mv) begin
          danger = 1'b1;
        end else if (s.battery_mv < thr.batt_warn_below_mv) begin
          warn = 1'b1;
        end
      end
      if (danger) begin
        show = DISP_DANGER;
      end else if (warn) begin
        show = DISP_WARN;
      end else begin
        show = DISP_SAFE;
      end
      phase_lit = 1'b1;
      since_cnt = 8'd1;
      lit = 1'b1;
    end

    o.display_state = show;
    o.flash_lit = lit;
    o.led_update = ({1'b0, show} != shown_state) || (lit != shown_phase);
    if (o.led_update) begin
      shown_state = {1'b0, show};
      shown_phase = lit;
    end

    o.red_level = LEVEL_OFF;
    o.green_level = LEVEL_OFF;
    o.blue_level = LEVEL_OFF;
    case (show)
      DISP_SAFE: begin
        o.green_level = LEVEL_FULL;
      end
      DISP_WARN: begin
        o.red_level = LEVEL_FULL;
        o.green_level = LEVEL_AMBER_GREEN;
      end
      DISP_DANGER: begin
        o.red_level = LEVEL_FULL;
      end
      default: begin
        o.red_level = lit ? LEVEL_FULL : LEVEL_OFF;
      end
    endcase
    return o;
  endfunction

  task automatic report(input string field, input logic [7:0] exp_v, input logic [7:0] got_v);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("status mismatch on %s: expected %0d, got %0d", field, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr.temp_danger_below = -12'sd0;
      thr.temp_warn_below = 12'sd100;
      thr.temp_warn_above = 12'sd350;
      thr.temp_danger_above = 12'sd450;
      thr.batt_danger_below_mv = 13'd3400;
      thr.batt_warn_below_mv = 13'd3700;
      thr.flash_period_items = 8'd5;
      since_cnt = 8'd0;
      phase_lit = 1'b1;
      shown_state = SHOWN_NONE;
      shown_phase = 1'b0;
      status_due_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_TEMP_DANGER_BELOW: thr.temp_danger_below = cfg_data[11:0];
          CFG_TEMP_WARN_BELOW:   thr.temp_warn_below = cfg_data[11:0];
          CFG_TEMP_WARN_ABOVE:   thr.temp_warn_above = cfg_data[11:0];
          CFG_TEMP_DANGER_ABOVE: thr.temp_danger_above = cfg_data[11:0];
          CFG_BATT_DANGER_BELOW: thr.batt_danger_below_mv = cfg_data;
          CFG_BATT_WARN_BELOW:   thr.batt_warn_below_mv = cfg_data;
          CFG_FLASH_PERIOD:      thr.flash_period_items = cfg_data[7:0];
          default: ;
        endcase
      end
      if (status_valid && status_ready) begin
        if (status_due_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("status transaction with nothing expected: state %0d", status.display_state);
          end
        end else begin
          want = status_due_q.pop_front();
          checked_cnt++;
          if (status.display_state !== want.display_state) begin
            report("display_state", want.display_state, status.display_state);
          end
          if (status.flash_lit !== want.flash_lit) begin
            report("flash_lit", want.flash_lit, status.flash_lit);
          end
          if (status.led_update !== want.led_update) begin
            report("led_update", want.led_update, status.led_update);
          end
          if (status.red_level !== want.red_level) begin
            report("red_level", want.red_level, status.red_level);
          end
          if (status.green_level !== want.green_level) begin
            report("green_level", want.green_level, status.green_level);
          end
          if (status.blue_level !== want.blue_level) begin
            report("blue_level", want.blue_level, status.blue_level);
          end
        end
      end
      if (snap_valid && snap_ready) begin
        status_due_q.push_back(predict_status(snap));
      end
    end
    outstanding <= status_due_q.size();
    errors <= err_cnt;
    checked <= checked_cnt;
  end

endmodule

[tb/safety_status_led_classifier_tb.sv]
// Top of the safety status LED classifier testbench: clock, reset, snapshot
// and register stimulus, receiver stalls and the verdict.
// Depends on ssl_pkg, the block and safety_status_led_classifier_checker.
module safety_status_led_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssl_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   snap_valid = 1'b0;
  logic                   snap_ready;
  ssl_in_t                snap = '0;
  logic                   status_valid;
  logic                   status_ready = 1'b0;
  ssl_out_t               status;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int errors;
  int outstanding;
  int checked;
  int cycle_cnt = 0;
  int hold_cnt = 0;
  int n_items = 0;
  int n_phases = 0;
  bit idle_on = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  safety_status_led_classifier DUT (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .status_valid (status_valid),
    .status_ready (status_ready),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  safety_status_led_classifier_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .status_valid (status_valid),
    .status_ready (status_ready),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding),
    .checked      (checked)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("safety_status_led_classifier_tb: done, errors");
      $finish;
    end
  end

  // receiver stalls in random bursts, only while idle_on is set
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      status_ready <= 1'b1;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (status_ready) begin
      if ($urandom_range(0, 6) == 0) begin
        status_ready <= 1'b0;
        hold_cnt <= $urandom_range(0, 18);
      end
    end else begin
      status_ready <= 1'b1;
      hold_cnt <= $urandom_range(0, 30);
    end
  end

  function automatic ssl_in_t snapshot(input int t, input bit tv, input int h, input bit hv,
                                       input int b, input bit bv, input bit imp,
                                       input bit ly, input bit ov);
    ssl_in_t s;
    s.temperature_tenths = t[11:0];
    s.temperature_valid = tv;
    s.humidity_tenths = h[9:0];
    s.humidity_valid = hv;
    s.battery_mv = b[12:0];
    s.battery_valid = bv;
    s.hard_impact = imp;
    s.lying_too_long = ly;
    s.remote_override = ov;
    return s;
  endfunction

  function automatic ssl_cfg_t make_cfg(input int dlo, input int wlo, input int whi,
                                        input int dhi, input int bd, input int bw,
                                        input int per);
    ssl_cfg_t c;
    c.temp_danger_below = dlo[11:0];
    c.temp_warn_below = wlo[11:0];
    c.temp_warn_above = whi[11:0];
    c.temp_danger_above = dhi[11:0];
    c.batt_danger_below_mv = bd[12:0];
    c.batt_warn_below_mv = bw[12:0];
    c.flash_period_items = per[7:0];
    return c;
  endfunction

  function automatic ssl_cfg_t rand_cfg(input int per);
    int v[4];
    int bd;
    int bw;
    int tmp;
    for (int i = 0; i < 4; i++) begin
      v[i] = int'($urandom_range(0, 1650)) - 400;
    end
    bd = $urandom_range(0, 5000);
    bw = $urandom_range(0, 5000);
    // mostly ordered windows, sometimes crossed ones
    if ($urandom_range(0, 4) != 0) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3 - i; j++) begin
          if (v[j] > v[j+1]) begin
            tmp = v[j];
            v[j] = v[j+1];
            v[j+1] = tmp;
          end
        end
      end
      if (bd > bw) begin
        tmp = bd;
        bd = bw;
        bw = tmp;
      end
    end
    return make_cfg(v[0], v[1], v[2], v[3], bd, bw, per);
  endfunction

  function automatic ssl_in_t rand_snap(input ssl_cfg_t c, input bit ov);
    int t;
    int h;
    int b;
    int nudge;
    nudge = int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 5))
      0: t = int'($urandom_range(0, 1650)) - 400;
      1: t = int'($signed(c.temp_danger_below)) + nudge;
      2: t = int'($signed(c.temp_warn_below)) + nudge;
      3: t = int'($signed(c.temp_warn_above)) + nudge;
      4: t = int'($signed(c.temp_danger_above)) + nudge;
      default: t = $urandom_range(0, 4095);
    endcase
    case ($urandom_range(0, 6))
      0, 1: h = $urandom_range(0, 1000);
      2: h = int'(HUM_DANGER_BELOW) + nudge;
      3: h = int'(HUM_WARN_BELOW) + nudge;
      4: h = int'(HUM_WARN_ABOVE) + nudge;
      5: h = int'(HUM_DANGER_ABOVE) + nudge;
      default: h = $urandom_range(0, 1023);
    endcase
    case ($urandom_range(0, 4))
      0, 1: b = $urandom_range(0, 5000);
      2: b = int'(c.batt_danger_below_mv) + nudge;
      3: b = int'(c.batt_warn_below_mv) + nudge;
      default: b = $urandom_range(0, 8191);
    endcase
    if (ov) begin
      return snapshot(t, $urandom_range(0, 1), h, $urandom_range(0, 1), b,
                      $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1), 1'b1);
    end
    return snapshot(t, $urandom_range(0, 6) != 0, h, $urandom_range(0, 6) != 0, b,
                    $urandom_range(0, 6) != 0, $urandom_range(0, 9) == 0,
                    $urandom_range(0, 9) == 0, 1'b0);
  endfunction

  task automatic send_snap(input ssl_in_t s);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      snap_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    snap_valid <= 1'b1;
    snap <= s;
    do @(posedge clk); while (!snap_ready);
    n_items++;
  endtask

  task automatic settle();
    snap_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic run_phase(input ssl_cfg_t c, input int n_new, input bit long_run);
    int done;
    int run_len;
    int max_run;
    settle();
    write_reg(CFG_TEMP_DANGER_BELOW, CFG_DATA_W'(c.temp_danger_below));
    write_reg(CFG_TEMP_WARN_BELOW, CFG_DATA_W'(c.temp_warn_below));
    write_reg(CFG_TEMP_WARN_ABOVE, CFG_DATA_W'(c.temp_warn_above));
    write_reg(CFG_TEMP_DANGER_ABOVE, CFG_DATA_W'(c.temp_danger_above));
    write_reg(CFG_BATT_DANGER_BELOW, c.batt_danger_below_mv);
    write_reg(CFG_BATT_WARN_BELOW, c.batt_warn_below_mv);
    write_reg(CFG_FLASH_PERIOD, CFG_DATA_W'(c.flash_period_items));
    cfg_write <= 1'b0;
    n_phases++;
    // hold override long enough to see the slowest toggle
    if (long_run) begin
      repeat (262) send_snap(rand_snap(c, 1'b1));
    end
    done = 0;
    while (done < n_new) begin
      if ($urandom_range(0, 3) == 0) begin
        max_run = 2 * int'(c.flash_period_items) + 3;
        if (max_run > 40) begin
          max_run = 40;
        end
        run_len = $urandom_range(1, max_run);
        repeat (run_len) send_snap(rand_snap(c, 1'b1));
        done += run_len;
      end else begin
        send_snap(rand_snap(c, 1'b0));
        done++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_snap(snapshot(200, 1, 500, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(200, 1, 500, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(-400, 1, 500, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(1250, 1, 500, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(50, 1, 500, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(400, 1, 500, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(0, 1, 500, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(200, 1, 0, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(200, 1, 1000, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(200, 1, 250, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(200, 1, 850, 1, 4000, 1, 0, 0, 0));
    send_snap(snapshot(200, 1, 500, 1, 0, 1, 0, 0, 0));
    send_snap(snapshot(200, 1, 500, 1, 3500, 1, 0, 0, 0));
    send_snap(snapshot(200, 1, 500, 1, 5000, 1, 0, 0, 0));
    send_snap(snapshot(200, 1, 500, 1, 4000, 1, 1, 0, 0));
    send_snap(snapshot(200, 1, 500, 1, 4000, 1, 0, 1, 0));
    send_snap(snapshot(-400, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (7) send_snap(snapshot(1250, 1, 1000, 1, 8191, 1, 1, 1, 1));
    send_snap(snapshot(200, 1, 500, 1, 4000, 1, 0, 0, 0));

    run_phase(make_cfg(-400, -400, 1250, 1250, 0, 0, 1), 40, 1'b0);
    run_phase(make_cfg(1250, 1250, -400, -400, 5000, 5000, 0), 40, 1'b0);
    run_phase(rand_cfg(255), 30, 1'b1);
    repeat (3) run_phase(rand_cfg($urandom_range(1, 12)), 35, 1'b0);
    idle_on <= 1'b0;
    run_phase(make_cfg(0, 100, 350, 450, 3400, 3700, 5), 40, 1'b0);
    settle();

    $display("%0d snapshots sent under reset values and %0d register settings,",
             n_items, n_phases);
    $display("%0d status transactions checked", checked);
    if (errors == 0 && outstanding == 0) begin
      $display("safety_status_led_classifier_tb: done, clean");
    end else begin
      $display("safety_status_led_classifier_tb: done, errors");
    end
    $finish;
  end

endmodule
